// File: rtl/cwd_pkg.sv
// Package for the capacitive wet detector: field widths, register map,
// reset values and the constants of the baseline filter. No dependencies.
package cwd_pkg;

    localparam int COUNT_W         = 16;
    localparam int NUM_FIELDS      = 8;
    localparam int NUM_SAMPLES_DEF = 8;
    localparam int INTERVAL_W      = 8;

    localparam int S_TDATA_W = COUNT_W * NUM_FIELDS;
    localparam int M_TDATA_W = 40;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_RESTORED_BASELINE = 1'b0;
    localparam logic REG_PERSIST_INTERVAL  = 1'b1;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd50;

    // Filter sum 19*baseline + median needs 21 bits. Dividing by 20 is a shift
    // by two and a multiply by ceil(2^21/5), exact for every reachable sum.
    localparam int                  SUM_W      = 21;
    localparam int                  QUOT_IN_W  = SUM_W - 2;
    localparam int                  RECIP_SH   = 21;
    localparam logic [QUOT_IN_W-1:0] RECIP_FIVE = 19'd419431;

    typedef logic [COUNT_W-1:0] level_t;

endpackage

// File: rtl/capacitive_wet_detector_unit.sv
// Top level of the capacitive wet detector: median of inverted counts,
// wet decision against an adaptive baseline, APB register port.
// Depends on cwd_pkg.

// The block takes one item per clock while the result side does not stall
// and returns one result item for each, registered in the last stage.
// The first stage registers the inverted counts, the second sorts them and
// registers the upper median, and the third compares the median with the
// baseline, updates the baseline and registers the result. The baseline loop
// closes within that last stage, so back-to-back items see each other's
// updates. A write to restored_baseline (address 0) loads the baseline; a
// write to persist_interval (address 4) sets how many dry updates pass
// between save requests.
module capacitive_wet_detector_unit
    import cwd_pkg::*;
#(
    parameter int NUM_SAMPLES = NUM_SAMPLES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // raw_count_0 .. raw_count_7, 16 bits each, raw_count_0 lowest
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // wet, seeded, median_level[15:0], baseline_level[15:0], save_request, zeros
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    level_t                  inv_reg [NUM_SAMPLES];
    logic                    a_valid_reg;
    level_t                  median_reg;
    logic                    b_valid_reg;
    logic                    m_valid_reg;
    logic [M_TDATA_W-1:0]    m_data_reg;

    level_t                  baseline_reg;
    level_t                  baseline_next;
    level_t                  restored_reg;
    logic [INTERVAL_W-1:0]   interval_reg;
    logic [INTERVAL_W-1:0]   dry_count_reg;
    logic [INTERVAL_W-1:0]   dry_count_next;

    logic                    adv_c;
    logic                    ready_b;
    logic                    move_a;
    logic                    move_b;
    logic                    cfg_wr;

    level_t                  sorted [NUM_SAMPLES];
    level_t                  swap_tmp;

    logic [COUNT_W+3:0]      med_x10;
    logic [COUNT_W+3:0]      base_x13;
    logic [SUM_W-1:0]        filt_sum;
    logic [2*QUOT_IN_W-1:0]  filt_prod;
    level_t                  filt_base;
    logic [INTERVAL_W-1:0]   dry_inc;
    logic                    wet;
    logic                    seeded;
    logic                    save;

    // Handshake chain through the three stages.
    assign adv_c         = m_axis_tready || !m_valid_reg;
    assign move_b        = b_valid_reg && adv_c;
    assign ready_b       = !b_valid_reg || adv_c;
    assign move_a        = a_valid_reg && ready_b;
    assign s_axis_tready = !a_valid_reg || ready_b;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_RESTORED_BASELINE: prdata[COUNT_W-1:0]    = restored_reg;
            REG_PERSIST_INTERVAL:  prdata[INTERVAL_W-1:0] = interval_reg;
            default:               prdata = '0;
        endcase
    end

    // Odd-even transposition sort of the registered levels.
    always_comb begin
        swap_tmp = '0;
        for (int k = 0; k < NUM_SAMPLES; k++) begin
            sorted[k] = inv_reg[k];
        end
        for (int s = 0; s < NUM_SAMPLES; s++) begin
            for (int i = (s & 1); i + 1 < NUM_SAMPLES; i += 2) begin
                if (sorted[i] > sorted[i+1]) begin
                    swap_tmp    = sorted[i];
                    sorted[i]   = sorted[i+1];
                    sorted[i+1] = swap_tmp;
                end
            end
        end
    end

    // Wet test and baseline filter.
    always_comb begin
        med_x10   = {1'b0, median_reg, 3'b000} + {3'b000, median_reg, 1'b0};
        base_x13  = {1'b0, baseline_reg, 3'b000} + {2'b00, baseline_reg, 2'b00}
                  + {4'b0000, baseline_reg};
        filt_sum  = {1'b0, baseline_reg, 4'b0000} + {4'b0000, baseline_reg, 1'b0}
                  + {5'b00000, baseline_reg} + {5'b00000, median_reg};
        filt_prod = filt_sum[SUM_W-1:2] * RECIP_FIVE;
        filt_base = filt_prod[RECIP_SH+COUNT_W-1:RECIP_SH];
        dry_inc   = dry_count_reg + 1'b1;

        wet            = 1'b0;
        seeded         = 1'b0;
        save           = 1'b0;
        baseline_next  = baseline_reg;
        dry_count_next = dry_count_reg;

        if (baseline_reg == '0) begin
            seeded        = 1'b1;
            save          = 1'b1;
            baseline_next = median_reg;
        end else begin
            wet = (med_x10 > base_x13);
            if (!wet) begin
                baseline_next  = filt_base;
                dry_count_next = dry_inc;
                if (dry_inc >= interval_reg) begin
                    save           = 1'b1;
                    dry_count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            baseline_reg  <= '0;
            restored_reg  <= '0;
            interval_reg  <= INTERVAL_RESET;
            dry_count_reg <= '0;
        end else begin
            if (s_axis_tready) begin
                a_valid_reg <= s_axis_tvalid;
            end
            if (ready_b) begin
                b_valid_reg <= a_valid_reg;
            end
            if (adv_c) begin
                m_valid_reg <= b_valid_reg;
            end
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_RESTORED_BASELINE: begin
                        restored_reg <= pwdata[COUNT_W-1:0];
                        baseline_reg <= pwdata[COUNT_W-1:0];
                    end
                    REG_PERSIST_INTERVAL: begin
                        interval_reg <= pwdata[INTERVAL_W-1:0];
                    end
                    default: begin
                        interval_reg <= interval_reg;
                    end
                endcase
            end else if (move_b) begin
                baseline_reg  <= baseline_next;
                dry_count_reg <= dry_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            for (int k = 0; k < NUM_SAMPLES; k++) begin
                inv_reg[k] <= ~s_axis_tdata[k*COUNT_W +: COUNT_W];
            end
        end
        if (move_a) begin
            median_reg <= sorted[NUM_SAMPLES/2];
        end
        if (move_b) begin
            m_data_reg <= {5'b00000, save, baseline_next, median_reg, seeded, wet};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_seed_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[1]) |->
            (!m_axis_tdata[0] && m_axis_tdata[34]
             && (m_axis_tdata[33:18] == m_axis_tdata[17:2])))
        else $error("seeding result is inconsistent");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (a_valid_reg && b_valid_reg && m_valid_reg && !m_axis_tready))
        else $error("input stalled while the pipeline has room");

    a_wet_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (move_b && wet && !cfg_wr) |=> (baseline_reg == $past(baseline_reg)))
        else $error("baseline moved on a wet item");

    a_save_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (move_b && save && !seeded && !cfg_wr) |=> (dry_count_reg == '0))
        else $error("dry count not cleared after a save request");
`endif

endmodule
